FILE: rtl/core/psps_pkg.sv
// ----------------------------------------------------------------------------
// psps_pkg: shared types and constants of the sphere section core
// Widths of the fixed-point datapath, register indexes, axis codes and the
// word carried along the square-root cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psps_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DIST_W   = COORD_BITS + 2;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int ROOT_W   = COORD_BITS;
  localparam int REM_W    = COORD_BITS + 2;
  localparam int NUM_CELLS = ROOT_W;
  localparam int IDX_W    = 3;

  localparam logic [COORD_BITS-1:0] CELL_RESET = COORD_BITS'(1) << FRAC_BITS;

  typedef enum logic [IDX_W-1:0] {
    REG_CUT_AXIS    = 3'd0,
    REG_PLANE_POS   = 3'd1,
    REG_CELL_SIZE_X = 3'd2,
    REG_CELL_SIZE_Y = 3'd3,
    REG_CELL_SIZE_Z = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic [1:0]            axis;
    logic [COORD_BITS-1:0] plane;
    logic [COORD_BITS-1:0] size_x;
    logic [COORD_BITS-1:0] size_y;
    logic [COORD_BITS-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]       n;
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    logic                  hit;
    logic                  last;
  } sq_t;

endpackage

`default_nettype wire

FILE: rtl/core/psps_if.sv
// ----------------------------------------------------------------------------
// psps_if: stream interfaces of the sphere section core
// One interface for incoming spheres and one for outgoing sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psps_sphere_if;
  logic                            valid;
  logic                            ready;
  logic [psps_pkg::COORD_BITS-1:0] center_x;
  logic [psps_pkg::COORD_BITS-1:0] center_y;
  logic [psps_pkg::COORD_BITS-1:0] center_z;
  logic [psps_pkg::COORD_BITS-1:0] sphere_radius;
  logic                            last_sphere;

  modport source (
    output valid, center_x, center_y, center_z, sphere_radius, last_sphere,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, sphere_radius, last_sphere,
    output ready
  );
endinterface

interface psps_section_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [psps_pkg::COORD_BITS-1:0] plane_u;
  logic [psps_pkg::COORD_BITS-1:0] plane_v;
  logic [psps_pkg::COORD_BITS-1:0] section_radius;
  logic                            last_out;

  modport source (
    output valid, hit, plane_u, plane_v, section_radius, last_out,
    input  ready
  );
  modport sink (
    input  valid, hit, plane_u, plane_v, section_radius, last_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/psps_front.sv
// ----------------------------------------------------------------------------
// psps_front: distance, wrap and radicand pipeline
// Five registered stages form the wrapped plane distance, the hit test and
// r^2 - d^2, and hand a word to the square-root cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire psps_pkg::cfg_t cfg_i,
  psps_sphere_if.sink         sphere_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output psps_pkg::sq_t       out_data_o
);

  localparam int CB = psps_pkg::COORD_BITS;
  localparam int DW = psps_pkg::DIST_W;
  localparam int NS = 5;

  logic [NS-1:0] valid_q;
  logic [NS:0]   rdy;

  // Stage 1
  logic [CB-1:0]        c_sel, size_sel, u_sel, v_sel;
  logic                 ok_sel;
  logic signed [DW-1:0] d1_d;
  logic signed [DW-1:0] d1_q;
  logic [CB-1:0]        size1_q, rad1_q, u1_q, v1_q;
  logic                 ok1_q, last1_q;

  // Stage 2
  logic signed [DW:0]   twice, size_s, size_neg;
  logic signed [DW-1:0] size_w, d2_d;
  logic signed [DW-1:0] d2_q;
  logic [CB-1:0]        rad2_q, u2_q, v2_q;
  logic                 ok2_q, last2_q;

  // Stage 3
  logic [DW-1:0]        ad;
  logic                 hit3_d;
  logic [CB-1:0]        ad3_q, rad3_q, u3_q, v3_q;
  logic                 hit3_q, last3_q;

  // Stage 4
  logic [2*CB-1:0]      rr4_q, aa4_q;
  logic [CB-1:0]        u4_q, v4_q;
  logic                 hit4_q, last4_q;

  // Stage 5
  psps_pkg::sq_t        sq5_q;

  assign rdy[NS] = out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end
  assign sphere_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= sphere_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    c_sel    = sphere_i.center_x;
    size_sel = cfg_i.size_x;
    u_sel    = sphere_i.center_y;
    v_sel    = sphere_i.center_z;
    ok_sel   = 1'b1;
    case (psps_pkg::axis_e'(cfg_i.axis))
      psps_pkg::AXIS_X: begin
        c_sel    = sphere_i.center_x;
        size_sel = cfg_i.size_x;
      end
      psps_pkg::AXIS_Y: begin
        c_sel    = sphere_i.center_y;
        size_sel = cfg_i.size_y;
        u_sel    = sphere_i.center_x;
      end
      psps_pkg::AXIS_Z: begin
        c_sel    = sphere_i.center_z;
        size_sel = cfg_i.size_z;
        u_sel    = sphere_i.center_x;
        v_sel    = sphere_i.center_y;
      end
      default: begin
        ok_sel   = 1'b0;
      end
    endcase
    d1_d = $signed({2'b00, cfg_i.plane}) - $signed({2'b00, c_sel});
  end

  always_comb begin
    twice    = {d1_q, 1'b0};
    size_s   = $signed({3'b000, size1_q});
    size_neg = -size_s;
    size_w   = $signed({2'b00, size1_q});
    if (twice > size_s) begin
      d2_d = d1_q - size_w;
    end else if (twice < size_neg) begin
      d2_d = d1_q + size_w;
    end else begin
      d2_d = d1_q;
    end
  end

  always_comb begin
    ad     = d2_q[DW-1] ? DW'(-d2_q) : DW'(d2_q);
    hit3_d = ok2_q && (ad < {2'b00, rad2_q});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      d1_q    <= d1_d;
      size1_q <= size_sel;
      rad1_q  <= sphere_i.sphere_radius;
      u1_q    <= u_sel;
      v1_q    <= v_sel;
      ok1_q   <= ok_sel;
      last1_q <= sphere_i.last_sphere;
    end
    if (rdy[1]) begin
      d2_q    <= d2_d;
      rad2_q  <= rad1_q;
      u2_q    <= u1_q;
      v2_q    <= v1_q;
      ok2_q   <= ok1_q;
      last2_q <= last1_q;
    end
    if (rdy[2]) begin
      ad3_q   <= hit3_d ? ad[CB-1:0] : '0;
      rad3_q  <= hit3_d ? rad2_q : '0;
      u3_q    <= hit3_d ? u2_q : '0;
      v3_q    <= hit3_d ? v2_q : '0;
      hit3_q  <= hit3_d;
      last3_q <= last2_q;
    end
    if (rdy[3]) begin
      rr4_q   <= rad3_q * rad3_q;
      aa4_q   <= ad3_q * ad3_q;
      u4_q    <= u3_q;
      v4_q    <= v3_q;
      hit4_q  <= hit3_q;
      last4_q <= last3_q;
    end
    if (rdy[4]) begin
      sq5_q.n    <= rr4_q - aa4_q;
      sq5_q.rem  <= '0;
      sq5_q.root <= '0;
      sq5_q.u    <= u4_q;
      sq5_q.v    <= v4_q;
      sq5_q.hit  <= hit4_q;
      sq5_q.last <= last4_q;
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign out_data_o  = sq5_q;

endmodule

`default_nettype wire

FILE: rtl/core/psps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psps_sqrt_cell: one digit cell of the integer square root chain
// Takes the next two radicand bits, decides one root bit and registers the
// updated partial remainder and root for the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psps_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire psps_pkg::sq_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output psps_pkg::sq_t      out_data_o
);

  localparam int RW = psps_pkg::REM_W;
  localparam int TW = psps_pkg::ROOT_W;
  localparam int NW = psps_pkg::SQ_W;

  logic          valid_q;
  psps_pkg::sq_t data_q, data_d;
  logic [RW-1:0] cur, trial;
  logic          take;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    cur         = {in_data_i.rem[RW-3:0], in_data_i.n[NW-1 -: 2]};
    trial       = {in_data_i.root, 2'b01};
    take        = cur >= trial;
    data_d      = in_data_i;
    data_d.n    = {in_data_i.n[NW-3:0], 2'b00};
    data_d.rem  = take ? cur - trial : cur;
    data_d.root = {in_data_i.root[TW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/periodic_sphere_plane_section_core.sv
// ----------------------------------------------------------------------------
// periodic_sphere_plane_section_core: plane section of spheres in a periodic cell
// Each sphere word on sphere_i yields one section word on section_o: the hit
// flag, the in-plane centre and the section radius floor(sqrt(r^2 - d^2)).
//
// Usage: program cut_axis, plane_position and the cell sizes through the
// write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while no word is in flight.
// Spheres stream in on sphere_i and sections leave on section_o in order,
// one section word per sphere word, with the last-sphere flag carried along.
// The datapath has five stages for distance, wrap, hit test, the two
// 32 x 32 squares and their difference, then one cell per root bit, 32 cells
// in a chain, each deciding one bit of the square root.
// Throughput is one word per cycle while section_o is not stalled. Every
// stage has its own valid bit, so a stall on section_o fills empty stages
// first; sphere_i.ready only falls once all stages hold a word and the
// receiver is not taking the output. Reset clears all valid bits and loads
// the register reset values; no word is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_sphere_plane_section_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [psps_pkg::IDX_W-1:0]        cfg_idx_i,
  input  wire logic [psps_pkg::COORD_BITS-1:0]   cfg_wdata_i,
  psps_sphere_if.sink                            sphere_i,
  psps_section_if.source                         section_o
);

  localparam int NC = psps_pkg::NUM_CELLS;

  psps_pkg::cfg_t cfg_q;
  logic           cell_valid [NC+1];
  logic           cell_ready [NC+1];
  psps_pkg::sq_t  cell_data  [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis   <= psps_pkg::AXIS_X;
      cfg_q.plane  <= '0;
      cfg_q.size_x <= psps_pkg::CELL_RESET;
      cfg_q.size_y <= psps_pkg::CELL_RESET;
      cfg_q.size_z <= psps_pkg::CELL_RESET;
    end else if (cfg_we_i) begin
      case (psps_pkg::reg_idx_e'(cfg_idx_i))
        psps_pkg::REG_CUT_AXIS:    cfg_q.axis   <= cfg_wdata_i[1:0];
        psps_pkg::REG_PLANE_POS:   cfg_q.plane  <= cfg_wdata_i;
        psps_pkg::REG_CELL_SIZE_X: cfg_q.size_x <= cfg_wdata_i;
        psps_pkg::REG_CELL_SIZE_Y: cfg_q.size_y <= cfg_wdata_i;
        psps_pkg::REG_CELL_SIZE_Z: cfg_q.size_z <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  psps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sphere_i    (sphere_i),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_data_o  (cell_data[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    psps_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_data_i   (cell_data[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_data_o  (cell_data[k+1])
    );
  end

  assign cell_ready[NC]           = section_o.ready;
  assign section_o.valid          = cell_valid[NC];
  assign section_o.hit            = cell_data[NC].hit;
  assign section_o.plane_u        = cell_data[NC].u;
  assign section_o.plane_v        = cell_data[NC].v;
  assign section_o.section_radius = cell_data[NC].root;
  assign section_o.last_out       = cell_data[NC].last;

  // A miss carries zero fields throughout the chain.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    section_o.valid && !section_o.hit |->
      section_o.section_radius == '0 && section_o.plane_u == '0 &&
      section_o.plane_v == '0)
    else $error("miss word with non-zero fields");

  // A true cut always leaves a non-zero section radius.
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    section_o.valid && section_o.hit |-> section_o.section_radius != '0)
    else $error("hit word with zero section radius");

  // The input only backs up when the whole pipeline is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sphere_i.ready |-> section_o.valid && !section_o.ready)
    else $error("input stalled without an output stall");

  // The final remainder never reaches twice the root plus one.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[NC] |->
      cell_data[NC].rem <= {cell_data[NC].root, 1'b0})
    else $error("square root remainder out of range");

endmodule

`default_nettype wire
